### design/fpa_pkg.sv
// package for the fixed-point alu: opcodes, status codes and defaults
`default_nettype none
package fpa_pkg;
  localparam int DataWidthDef = 32;
  localparam int FracBitsDef  = 8;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_CMP = 4'd4, OP_MIN = 4'd5, OP_MAX = 4'd6, OP_FROM_INT = 4'd7,
    OP_TO_INT = 4'd8, OP_INC = 4'd9, OP_DEC = 4'd10
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
endpackage
`default_nettype wire

### design/fpa_div.sv
// pipelined restoring divider: one quotient bit per stage, rounded, sign applied
`default_nettype none
module fpa_div import fpa_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int FB         = FracBitsDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic [DATA_WIDTH-1:0] in_mag_a,
  input  wire logic [DATA_WIDTH-1:0] in_mag_b,
  input  wire logic                  in_neg,
  input  wire logic [3:0]            in_tag,
  input  wire logic [DATA_WIDTH+1:0] in_side,
  output logic                       out_valid,
  output logic [DATA_WIDTH-1:0]      out_value,
  output logic                       out_ovf,
  output logic [3:0]                 out_tag,
  output logic [DATA_WIDTH+1:0]      out_side
);
  // numerator a << FB; quotient needs DATA_WIDTH + FB bits
  localparam int NW = DATA_WIDTH + FB;
  localparam int W  = DATA_WIDTH;

  logic          v_r    [NW+1];
  logic [NW-1:0] num_r  [NW+1];
  logic [W:0]    rem_r  [NW+1];
  logic [W-1:0]  den_r  [NW+1];
  logic          neg_r  [NW+1];
  logic [3:0]    tag_r  [NW+1];
  logic [W+1:0]  side_r [NW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NW; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int i = 0; i < NW; i++) v_r[i+1] <= v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    num_r[0]  <= {in_mag_a, {FB{1'b0}}};
    rem_r[0]  <= '0;
    den_r[0]  <= in_mag_b;
    neg_r[0]  <= in_neg;
    tag_r[0]  <= in_tag;
    side_r[0] <= in_side;
  end

  // each stage shifts in one numerator bit and one quotient bit
  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [W+1:0] sh;
    logic [W+1:0] df;
    assign sh = {rem_r[g], num_r[g][NW-1]};
    assign df = sh - {2'b00, den_r[g]};
    always_ff @(posedge clk) begin
      den_r[g+1]  <= den_r[g];
      neg_r[g+1]  <= neg_r[g];
      tag_r[g+1]  <= tag_r[g];
      side_r[g+1] <= side_r[g];
      if (!df[W+1]) begin
        rem_r[g+1] <= df[W:0];
        num_r[g+1] <= {num_r[g][NW-2:0], 1'b1};
      end else begin
        rem_r[g+1] <= sh[W:0];
        num_r[g+1] <= {num_r[g][NW-2:0], 1'b0};
      end
    end
  end

  // round: remainder >= d - remainder, i.e. 2r >= d
  logic [W+1:0] r2;
  logic [NW:0]  q;
  logic [NW:0]  lim;
  assign r2  = {rem_r[NW], 1'b0};
  assign q   = {1'b0, num_r[NW]} + {{NW{1'b0}}, (r2 >= {2'b00, den_r[NW]})};
  assign lim = neg_r[NW] ? {{(NW-W+1){1'b0}}, 1'b1, {(W-1){1'b0}}}
                         : {{(NW-W+1){1'b0}}, 1'b0, {(W-1){1'b1}}};

  always_comb begin
    out_valid = v_r[NW];
    out_tag   = tag_r[NW];
    out_side  = side_r[NW];
    out_ovf   = q > lim;
    if (out_ovf) out_value = neg_r[NW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else out_value = neg_r[NW] ? W'(-q[W-1:0]) : q[W-1:0];
  end
endmodule
`default_nettype wire

### design/fixed_point_alu_core.sv
// top level of the signed fixed-point alu
//
//  channel | ports                                          | direction
//  input   | start, busy, in_req_type, in_operand_a/b       | in (busy out)
//  result  | out_valid, out_result_value, out_*_flag, out_status | out
//
// one word may enter every cycle; busy is tied low. every word passes through the
// same stages: one operand stage, one product stage, the divider's input stage,
// DATA_WIDTH + FB divider stages (one quotient bit each), then one output stage;
// the divider pipeline sets the depth. the other operations ride alongside in a
// delay line so results stay in order.
// reset clears the valid bits only. the receiver cannot stall.
`default_nettype none
module fixed_point_alu_core import fpa_pkg::*; #(
  parameter int FRAC_BITS  = FracBitsDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [3:0]                   in_req_type,
  input  wire logic signed [DATA_WIDTH-1:0] in_operand_a,
  input  wire logic signed [DATA_WIDTH-1:0] in_operand_b,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      out_result_value,
  output logic                              out_less_flag,
  output logic                              out_equal_flag,
  output logic                              out_greater_flag,
  output logic [1:0]                        out_status
);
  localparam int W  = DATA_WIDTH;
  // fraction bits clipped to at most DATA_WIDTH - 2
  localparam int FB = (FRAC_BITS < W - 1) ? FRAC_BITS : W - 2;

  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MaxNeg = {1'b1, {(W-1){1'b0}}};

  assign busy = 1'b0;

  // stage 0: capture operands, take magnitudes
  logic         v0_r;
  logic [3:0]   op0_r;
  logic [W-1:0] a0_r, b0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start;
    op0_r <= in_req_type;
    a0_r  <= in_operand_a;
    b0_r  <= in_operand_b;
  end

  logic [W-1:0] ma, mb;
  assign ma = a0_r[W-1] ? W'(-a0_r) : a0_r;
  assign mb = b0_r[W-1] ? W'(-b0_r) : b0_r;

  // stage 1: magnitude product (rounded later) and simple results
  logic [2*W-1:0] prod_r;
  logic           pneg_r;
  logic [W-1:0]   smp_nxt, smp_r;
  logic [1:0]     sst_nxt, sst_r;
  logic [2:0]     flg_nxt, flg_r;
  logic [3:0]     op1_r;
  logic           v1_r;
  logic [W-1:0]   a1_r, b1_r;

  logic lt, gt, eq;
  logic [W:0] sum;
  assign lt = $signed(a0_r) < $signed(b0_r);
  assign gt = $signed(a0_r) > $signed(b0_r);
  assign eq = a0_r == b0_r;

  always_comb begin
    logic [W:0] ea, eb;
    logic [W+FB:0] sh;
    ea = {a0_r[W-1], a0_r};
    eb = {b0_r[W-1], b0_r};
    sum = '0;
    smp_nxt = '0;
    sst_nxt = ST_OK;
    flg_nxt = 3'b000;
    sh = {{(FB+1){a0_r[W-1]}}, a0_r} <<< FB;
    case (op0_r)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (op0_r == OP_ADD) sum = ea + eb;
        else if (op0_r == OP_SUB) sum = ea - eb;
        else if (op0_r == OP_INC) sum = ea + (W+1)'(1);
        else sum = ea - (W+1)'(1);
        if (sum[W] != sum[W-1]) begin
          sst_nxt = ST_OVF;
          smp_nxt = sum[W] ? MaxNeg : MaxPos;
        end else smp_nxt = sum[W-1:0];
      end
      OP_CMP: flg_nxt = {lt, eq, gt};
      OP_MIN: begin flg_nxt = {lt, eq, gt}; smp_nxt = lt ? a0_r : b0_r; end
      OP_MAX: begin flg_nxt = {lt, eq, gt}; smp_nxt = gt ? a0_r : b0_r; end
      OP_FROM_INT: begin
        if (sh[W+FB:W-1] != {(FB+2){sh[W+FB]}}) begin
          sst_nxt = ST_OVF;
          smp_nxt = a0_r[W-1] ? MaxNeg : MaxPos;
        end else smp_nxt = sh[W-1:0];
      end
      OP_TO_INT: smp_nxt = W'($signed(a0_r) >>> FB);
      default: smp_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r;
    prod_r <= ma * mb;
    pneg_r <= a0_r[W-1] ^ b0_r[W-1];
    smp_r  <= smp_nxt;
    sst_r  <= sst_nxt;
    flg_r  <= flg_nxt;
    op1_r  <= op0_r;
    a1_r   <= a0_r;
    b1_r   <= b0_r;
  end

  // stage 2: round the product
  logic [2*W:0] pr;
  logic [W:0]   mlim;
  logic [W-1:0] mres_nxt;
  logic         movf_nxt;
  assign pr   = ({1'b0, prod_r} + (2*W+1)'(1 << (FB - 1))) >> FB;
  assign mlim = pneg_r ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
  always_comb begin
    movf_nxt = (pr[2*W:W+1] != '0) || (pr[W:0] > mlim);
    if (movf_nxt) mres_nxt = pneg_r ? MaxNeg : MaxPos;
    else mres_nxt = pneg_r ? W'(-pr[W-1:0]) : pr[W-1:0];
  end

  // carried word: {status, value} packed into side channel
  logic [W+1:0] side;
  logic [W-1:0] val2;
  logic [1:0]   st2;
  always_comb begin
    val2 = smp_r;
    st2  = sst_r;
    if (op1_r == OP_MUL) begin
      val2 = mres_nxt;
      st2  = movf_nxt ? ST_OVF : ST_OK;
    end
  end
  assign side = {st2, val2};

  // divider with divide-by-zero handled at output; flags ride in a delay line
  logic         dv_v, dv_ovf;
  logic [W-1:0] dv_val;
  logic [3:0]   dv_tag;
  logic [W+1:0] dv_side;
  logic [2:0]   flg_d_r [W+FB+1];
  logic         z_d_r   [W+FB+1];
  logic         an_d_r  [W+FB+1];

  fpa_div #(.DATA_WIDTH(W), .FB(FB)) u_div (
    .clk(clk), .rst_n(rst_n),
    .in_valid(v1_r),
    .in_mag_a(a1_r[W-1] ? W'(-a1_r) : a1_r),
    .in_mag_b(b1_r[W-1] ? W'(-b1_r) : b1_r),
    .in_neg(a1_r[W-1] ^ b1_r[W-1]),
    .in_tag(op1_r), .in_side(side),
    .out_valid(dv_v), .out_value(dv_val), .out_ovf(dv_ovf),
    .out_tag(dv_tag), .out_side(dv_side)
  );

  always_ff @(posedge clk) begin
    flg_d_r[0] <= flg_r;
    z_d_r[0]   <= b1_r == '0;
    an_d_r[0]  <= a1_r[W-1];
    for (int i = 0; i < W + FB; i++) begin
      flg_d_r[i+1] <= flg_d_r[i];
      z_d_r[i+1]   <= z_d_r[i];
      an_d_r[i+1]  <= an_d_r[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= dv_v;
    {out_less_flag, out_equal_flag, out_greater_flag} <= flg_d_r[W+FB];
    if (dv_tag == OP_DIV) begin
      if (z_d_r[W+FB]) begin
        out_result_value <= an_d_r[W+FB] ? MaxNeg : MaxPos;
        out_status       <= ST_DIV0;
      end else begin
        out_result_value <= dv_val;
        out_status       <= dv_ovf ? ST_OVF : ST_OK;
      end
    end else begin
      out_result_value <= dv_side[W-1:0];
      out_status       <= dv_side[W+1:W];
    end
  end
endmodule
`default_nettype wire
